[rtl/ece_pkg.sv]
// Shared types, constants and helpers for the easing curve evaluator.
// Used by ece_div, ece_isqrt and easing_curve_evaluator; no dependencies.
package ece_pkg;

   // Normalized time 2t is Q1.16 below 2.0, so 17 quotient bits
   localparam int HQ_WIDTH    = 17;
   localparam int DIV_STAGES  = 17;
   localparam int SQRT_STAGES = 17;
   localparam int SQRT_WIDTH  = 34;
   // Stage map: divider 17, curve 4, root runs beside curve stages 3..4 plus 15
   localparam int F_DELAY     = 15;
   localparam int LATENCY     = 38;

   localparam int Q_WIDTH = 21;
   typedef logic signed [Q_WIDTH-1:0] q_type;

   localparam q_type ONE_Q16 = 21'sd65536;
   localparam q_type TWO_Q16 = 21'sd131072;
   localparam q_type BACK_S  = 21'sd58982;
   localparam q_type BACK_S1 = 21'sd124518;

   typedef enum logic [2:0] {
      CURVE_LINEAR = 3'd0,
      CURVE_QUINT  = 3'd1,
      CURVE_BACK   = 3'd2,
      CURVE_QUART  = 3'd3,
      CURVE_QUAD   = 3'd4,
      CURVE_EXPO   = 3'd5,
      CURVE_CUBIC  = 3'd6,
      CURVE_CIRC   = 3'd7
   } curve_type;

   typedef enum logic [1:0] {
      CSR_CURVE    = 2'd0,
      CSR_START    = 2'd1,
      CSR_END      = 2'd2,
      CSR_DURATION = 2'd3
   } csr_idx_type;

   // Q16 product, truncated toward zero
   function automatic q_type qmul(input q_type a, input q_type b);
      logic signed [2*Q_WIDTH-1:0] p;
      logic signed [2*Q_WIDTH-1:0] r;
      begin
         p = a * b;
         r = p + (p[2*Q_WIDTH-1] ? (2*Q_WIDTH)'(65535) : '0);
         return Q_WIDTH'(r >>> 16);
      end
   endfunction

   // 2^(-i/16) in Q16
   function automatic logic [16:0] exp2_tab(input logic [4:0] idx);
      case (idx)
         5'd0:    return 17'd65536;
         5'd1:    return 17'd62757;
         5'd2:    return 17'd60097;
         5'd3:    return 17'd57549;
         5'd4:    return 17'd55109;
         5'd5:    return 17'd52773;
         5'd6:    return 17'd50535;
         5'd7:    return 17'd48393;
         5'd8:    return 17'd46341;
         5'd9:    return 17'd44376;
         5'd10:   return 17'd42495;
         5'd11:   return 17'd40693;
         5'd12:   return 17'd38968;
         5'd13:   return 17'd37316;
         5'd14:   return 17'd35734;
         5'd15:   return 17'd34219;
         default: return 17'd32768;
      endcase
   endfunction

endpackage

[rtl/easing_curve_evaluator.sv]
// Top level of the easing curve evaluator: config registers, curve stages, output.
// Depends on ece_pkg, ece_div and ece_isqrt.
//
// Takes one elapsed-time sample per clock on start and returns the eased
// position as a one-cycle rsp_valid strobe; busy is never raised, so
// samples may be issued back to back. The latency is set by the 17-stage
// divider that normalizes time, the curve-math stages and the 17-stage
// square root used by the ease-in circ curve, which every sample passes
// through to keep results in order. Results cannot be held off. The user
// must write configuration through the csr_ port while no sample is in
// flight; the block does not enforce it. There is no clearing pass after reset.
module easing_curve_evaluator #(
   parameter int POS_WIDTH  = 16,
   parameter int TIME_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [TIME_WIDTH-1:0]         req_elapsed_ms,
   output logic                          rsp_valid,
   output logic signed [POS_WIDTH-1:0]   rsp_eased_position,
   output logic                          rsp_finished,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [((POS_WIDTH > TIME_WIDTH) ? POS_WIDTH : TIME_WIDTH)-1:0] csr_write_data
);
   import ece_pkg::*;

   localparam int CW = POS_WIDTH + 1;
   localparam int PW = POS_WIDTH + 1 + Q_WIDTH;
   localparam logic signed [PW-1:0] PMAX = PW'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
   localparam logic signed [PW-1:0] PMIN = PW'(-(64'sd1 <<< (POS_WIDTH - 1)));

   // Configuration registers
   curve_type                    curve_ff;
   logic signed [POS_WIDTH-1:0]  start_ff;
   logic signed [POS_WIDTH-1:0]  end_ff;
   logic [TIME_WIDTH-1:0]        dur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_ff <= CURVE_LINEAR;
         start_ff <= '0;
         end_ff   <= '0;
         dur_ff   <= TIME_WIDTH'(1000);
      end else if (csr_write_enable) begin
         case (csr_idx_type'(csr_index))
            CSR_CURVE:    curve_ff <= curve_type'(csr_write_data[2:0]);
            CSR_START:    start_ff <= csr_write_data[POS_WIDTH-1:0];
            CSR_END:      end_ff   <= csr_write_data[POS_WIDTH-1:0];
            CSR_DURATION: dur_ff   <= csr_write_data[TIME_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Valid and finished flags travel beside the data
   logic                  accept;
   logic                  fin_in;
   logic [LATENCY-2:0]    vld_ff;
   logic [LATENCY-2:0]    fin_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign fin_in = (req_elapsed_ms >= dur_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LATENCY-3:0], accept};
      end
      fin_ff <= {fin_ff[LATENCY-3:0], fin_in};
   end

   // Normalized time: h = 2t in Q16
   logic [HQ_WIDTH-1:0] h_q;

   ece_div #(.TIME_WIDTH(TIME_WIDTH)) u_div (
      .clock    (clock),
      .dividend (req_elapsed_ms),
      .divisor  (dur_ff),
      .quotient (h_q)
   );

   // Curve stage 1: squares, back terms, expo table lookup
   q_type  h_s, t_s, u_s, bv_s;
   logic   hlow;
   logic [19:0] em;
   q_type  c1_u_ff, c1_t_ff, c1_u2_ff, c1_tt_ff, c1_b2_ff, c1_b1_ff;
   logic   c1_blow_ff, c1_tzero_ff;
   logic [16:0] c1_ehi_ff, c1_elo_ff;
   logic [11:0] c1_efr_ff;
   logic [3:0]  c1_en_ff;

   always_comb begin
      h_s  = q_type'({4'b0, h_q});
      t_s  = q_type'({5'b0, h_q[HQ_WIDTH-1:1]});
      u_s  = t_s - ONE_Q16;
      hlow = (h_s < ONE_Q16);
      bv_s = hlow ? h_s : (h_s - TWO_Q16);
      em   = hlow ? 20'((ONE_Q16 - h_s) * 10) : 20'((h_s - ONE_Q16) * 10);
   end

   always_ff @(posedge clock) begin
      c1_u_ff     <= u_s;
      c1_t_ff     <= t_s;
      c1_tzero_ff <= (h_q[HQ_WIDTH-1:1] == '0);
      c1_u2_ff    <= qmul(u_s, u_s);
      c1_tt_ff    <= qmul(t_s, t_s);
      c1_b2_ff    <= qmul(bv_s, bv_s);
      c1_b1_ff    <= qmul(BACK_S1, bv_s) + (hlow ? -BACK_S : BACK_S);
      c1_blow_ff  <= hlow;
      c1_ehi_ff   <= exp2_tab({1'b0, em[15:12]});
      c1_elo_ff   <= exp2_tab(5'({1'b0, em[15:12]} + 5'd1));
      c1_efr_ff   <= em[11:0];
      c1_en_ff    <= em[19:16];
   end

   // Curve stage 2: cube, back product, expo interpolation, circ radicand
   q_type       g_s;
   logic [23:0] ed_s;
   q_type       c2_u_ff, c2_t_ff, c2_u3_ff, c2_tt_ff, c2_back_ff;
   logic [16:0] c2_ev_ff;
   logic [16:0] c2_q_ff;
   logic [3:0]  c2_en_ff;
   logic        c2_elow_ff, c2_tzero_ff;

   always_comb begin
      g_s  = qmul(c1_b2_ff, c1_b1_ff) + (c1_blow_ff ? q_type'(0) : TWO_Q16);
      ed_s = {7'b0, c1_ehi_ff - c1_elo_ff} * {12'b0, c1_efr_ff};
   end

   always_ff @(posedge clock) begin
      c2_u_ff     <= c1_u_ff;
      c2_t_ff     <= c1_t_ff;
      c2_u3_ff    <= qmul(c1_u2_ff, c1_u_ff);
      c2_tt_ff    <= c1_tt_ff;
      c2_back_ff  <= (g_s + q_type'({20'b0, g_s[Q_WIDTH-1]})) >>> 1;
      c2_ev_ff    <= c1_ehi_ff - 17'(ed_s >> 12);
      c2_en_ff    <= c1_en_ff;
      c2_elow_ff  <= c1_blow_ff;
      c2_tzero_ff <= c1_tzero_ff;
      c2_q_ff     <= (c1_tt_ff >= ONE_Q16) ? 17'd0 : 17'(ONE_Q16 - c1_tt_ff);
   end

   // Square root for ease-in circ
   logic [HQ_WIDTH-1:0] root;

   ece_isqrt u_isqrt (
      .clock    (clock),
      .radicand ({1'b0, c2_q_ff, 16'b0}),
      .root     (root)
   );

   // Curve stage 3: fourth power, cubic, expo result
   logic [16:0] es_s;
   q_type       c3_u_ff, c3_t_ff, c3_u4_ff, c3_tt_ff, c3_back_ff, c3_exp_ff, c3_cubic_ff;

   assign es_s = c2_ev_ff >> c2_en_ff;

   always_ff @(posedge clock) begin
      c3_u_ff     <= c2_u_ff;
      c3_t_ff     <= c2_t_ff;
      c3_u4_ff    <= qmul(c2_u3_ff, c2_u_ff);
      c3_tt_ff    <= c2_tt_ff;
      c3_back_ff  <= c2_back_ff;
      c3_cubic_ff <= c2_u3_ff + ONE_Q16;
      if (c2_tzero_ff) begin
         c3_exp_ff <= '0;
      end else if (c2_elow_ff) begin
         c3_exp_ff <= q_type'({4'b0, es_s}) >>> 1;
      end else begin
         c3_exp_ff <= (TWO_Q16 - q_type'({4'b0, es_s})) >>> 1;
      end
   end

   // Curve stage 4: fifth power and selection of every curve but circ
   q_type f4_s;
   q_type f4_ff;
   q_type fd_ff [0:F_DELAY-1];

   always_comb begin
      case (curve_ff)
         CURVE_LINEAR: f4_s = c3_t_ff;
         CURVE_QUINT:  f4_s = qmul(c3_u4_ff, c3_u_ff) + ONE_Q16;
         CURVE_BACK:   f4_s = c3_back_ff;
         CURVE_QUART:  f4_s = ONE_Q16 - c3_u4_ff;
         CURVE_QUAD:   f4_s = c3_tt_ff;
         CURVE_EXPO:   f4_s = c3_exp_ff;
         CURVE_CUBIC:  f4_s = c3_cubic_ff;
         default:      f4_s = c3_t_ff;
      endcase
   end

   // Hold the fraction until the root comes out
   always_ff @(posedge clock) begin
      f4_ff    <= f4_s;
      fd_ff[0] <= f4_ff;
      for (int i = 1; i < F_DELAY; i++) begin
         fd_ff[i] <= fd_ff[i-1];
      end
   end

   // Scale by the change amount
   q_type                 f_s;
   logic signed [CW-1:0]  change_s;
   logic signed [PW-1:0]  prod_ff;

   always_comb begin
      f_s      = (curve_ff == CURVE_CIRC) ? (ONE_Q16 - q_type'({4'b0, root}))
                                          : fd_ff[F_DELAY-1];
      change_s = CW'(end_ff) - CW'(start_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(change_s) * PW'(f_s);
   end

   // Truncate, offset by start, saturate; finished samples return the end position
   logic signed [PW-1:0] tr_s, sum_s;
   logic signed [PW-1:0] pos_s;
   logic                 rsp_valid_ff, rsp_fin_ff;
   logic signed [POS_WIDTH-1:0] rsp_pos_ff;

   always_comb begin
      tr_s  = (prod_ff + (prod_ff[PW-1] ? PW'(65535) : PW'(0))) >>> 16;
      sum_s = tr_s + PW'(start_ff);
      if (sum_s > PMAX) begin
         pos_s = PMAX;
      end else if (sum_s < PMIN) begin
         pos_s = PMIN;
      end else begin
         pos_s = sum_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[LATENCY-2];
      end
      rsp_fin_ff <= fin_ff[LATENCY-2];
      rsp_pos_ff <= fin_ff[LATENCY-2] ? end_ff : pos_s[POS_WIDTH-1:0];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_finished       = rsp_fin_ff;
   assign rsp_eased_position = rsp_pos_ff;

`ifndef SYNTHESIS
   // circ radicand stays within (0, 1] for unfinished samples
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_STAGES+1] && !fin_ff[DIV_STAGES+1] |-> (c2_q_ff != 17'd0) && (c2_q_ff <= 17'd65536))
      else $error("circ radicand out of range");

   // root of a value at most one never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[LATENCY-3] && !fin_ff[LATENCY-3] |-> (root <= 17'd65536))
      else $error("square root out of range");

   // every result answers an earlier transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a matching transaction");
`endif

endmodule

[rtl/ece_div.sv]
// Pipelined restoring divider: (dividend << 17) / divisor, one quotient bit a stage.
// Depends on ece_pkg. Dividend must be below divisor for a meaningful result.
module ece_div #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                          clock,
   input  logic [TIME_WIDTH-1:0]         dividend,
   input  logic [TIME_WIDTH-1:0]         divisor,
   output logic [ece_pkg::HQ_WIDTH-1:0]  quotient
);
   import ece_pkg::*;

   logic [TIME_WIDTH-1:0] rem_ff [0:DIV_STAGES-1];
   logic [HQ_WIDTH-1:0]   quo_ff [0:DIV_STAGES-1];

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic [TIME_WIDTH-1:0] rem_prev;
      logic [HQ_WIDTH-1:0]   quo_prev;
      logic [TIME_WIDTH:0]   shifted;
      logic [TIME_WIDTH:0]   diff;
      logic                  take;

      if (i == 0) begin : g_first
         assign rem_prev = dividend;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign quo_prev = quo_ff[i-1];
      end

      // shift in a zero, subtract if it fits
      assign shifted = {rem_prev, 1'b0};
      assign diff    = shifted - {1'b0, divisor};
      assign take    = (shifted >= {1'b0, divisor});

      always_ff @(posedge clock) begin
         rem_ff[i] <= take ? diff[TIME_WIDTH-1:0] : shifted[TIME_WIDTH-1:0];
         quo_ff[i] <= {quo_prev[HQ_WIDTH-2:0], take};
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule

[rtl/ece_isqrt.sv]
// Pipelined integer square root of a 34-bit value, one result bit a stage.
// Depends on ece_pkg.
module ece_isqrt (
   input  logic                            clock,
   input  logic [ece_pkg::SQRT_WIDTH-1:0]  radicand,
   output logic [ece_pkg::HQ_WIDTH-1:0]    root
);
   import ece_pkg::*;

   logic [SQRT_WIDTH-1:0] x_ff [0:SQRT_STAGES-1];
   logic [SQRT_WIDTH-1:0] r_ff [0:SQRT_STAGES-1];

   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
      localparam logic [SQRT_WIDTH-1:0] BITV = SQRT_WIDTH'(1) << (32 - 2 * i);
      logic [SQRT_WIDTH-1:0] x_prev;
      logic [SQRT_WIDTH-1:0] r_prev;
      logic [SQRT_WIDTH-1:0] trial;
      logic                  take;

      if (i == 0) begin : g_first
         assign x_prev = radicand;
         assign r_prev = '0;
      end else begin : g_next
         assign x_prev = x_ff[i-1];
         assign r_prev = r_ff[i-1];
      end

      assign trial = r_prev + BITV;
      assign take  = (x_prev >= trial);

      always_ff @(posedge clock) begin
         x_ff[i] <= take ? (x_prev - trial) : x_prev;
         r_ff[i] <= take ? ((r_prev >> 1) + BITV) : (r_prev >> 1);
      end
   end

   assign root = r_ff[SQRT_STAGES-1][HQ_WIDTH-1:0];

endmodule

[test/tb.sv]
// Self-checking testbench for easing_curve_evaluator: directed and random phases.
// Depends on ece_pkg and the RTL top; holds its own bit-exact position predictor.
`timescale 1ns / 1ps

module tb;
   import ece_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_elapsed_ms;
   logic        rsp_valid;
   logic signed [15:0] rsp_eased_position;
   logic        rsp_finished;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;

   easing_curve_evaluator u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_elapsed_ms     (req_elapsed_ms),
      .rsp_valid          (rsp_valid),
      .rsp_eased_position (rsp_eased_position),
      .rsp_finished       (rsp_finished),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   // shadow copy of the configuration
   logic [2:0]         sh_curve;
   logic signed [15:0] sh_start;
   logic signed [15:0] sh_end;
   logic [15:0]        sh_dur;

   // expected positions and done flags, oldest first
   logic signed [15:0] exp_pos_q[$];
   logic               exp_fin_q[$];
   int n_sent, n_checked, n_errors;
   int curve_hits[8];

   longint exp2_lut[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                            46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
                            32768};

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[easing_curve_evaluator] ERROR");
      $finish;
   end

   function automatic longint fx_mul(longint a, longint b);
      return (a * b) / 65536;
   endfunction

   function automatic longint pow2_neg(longint m);
      longint n, r, hi, lo, v;
      n  = m >> 16;
      r  = m & 16'hFFFF;
      hi = exp2_lut[r >> 12];
      lo = exp2_lut[(r >> 12) + 1];
      v  = hi - (((hi - lo) * (r & 12'hFFF)) >> 12);
      if (n > 16) n = 16;
      return v >> n;
   endfunction

   function automatic longint int_sqrt(longint x);
      longint res, bitv;
      res  = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // curve fraction in Q16 for normalized time t and doubled time h
   function automatic longint curve_frac(logic [2:0] sel, longint t, longint h);
      longint u, v, g, q;
      u = t - 65536;
      case (sel)
         CURVE_QUINT: return fx_mul(fx_mul(fx_mul(fx_mul(u, u), u), u), u) + 65536;
         CURVE_BACK: begin
            if (h < 65536) begin
               g = fx_mul(fx_mul(h, h), fx_mul(124518, h) - 58982);
            end else begin
               v = h - 131072;
               g = fx_mul(fx_mul(v, v), fx_mul(124518, v) + 58982) + 131072;
            end
            return g / 2;
         end
         CURVE_QUART: return 65536 - fx_mul(fx_mul(fx_mul(u, u), u), u);
         CURVE_QUAD:  return fx_mul(t, t);
         CURVE_EXPO: begin
            if (t == 0) return 0;
            if (h < 65536) return pow2_neg(10 * (65536 - h)) / 2;
            return (131072 - pow2_neg(10 * (h - 65536))) / 2;
         end
         CURVE_CUBIC: return fx_mul(fx_mul(u, u), u) + 65536;
         CURVE_CIRC: begin
            q = 65536 - fx_mul(t, t);
            if (q < 0) q = 0;
            return 65536 - int_sqrt(q << 16);
         end
         default: return t;
      endcase
   endfunction

   // expected position for one elapsed sample under the shadow configuration
   task automatic predict_position(input logic [15:0] el);
      longint t, h, f, pos, s, e;
      logic   fin;
      s = sh_start;
      e = sh_end;
      if (sh_dur == 0 || el >= sh_dur) begin
         fin = 1'b1;
         pos = e;
      end else begin
         t   = (longint'(el) << 16) / longint'(sh_dur);
         h   = (longint'(el) << 17) / longint'(sh_dur);
         f   = curve_frac(sh_curve, t, h);
         fin = 1'b0;
         pos = s + ((e - s) * f) / 65536;
         if (pos > 32767) pos = 32767;
         if (pos < -32768) pos = -32768;
      end
      exp_pos_q = {exp_pos_q, pos[15:0]};
      exp_fin_q = {exp_fin_q, fin};
   endtask

   // one sample transaction; start stays high for a following send
   task automatic send_sample(input logic [15:0] el);
      logic was_busy;
      start          <= 1'b1;
      req_elapsed_ms <= el;
      do begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
      end while (was_busy);
      predict_position(el);
      curve_hits[sh_curve]++;
      n_sent++;
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // wait for all results, then let the pipeline settle before config writes
   task automatic drain;
      idle_cycles(1);
      while (exp_pos_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_CURVE: sh_curve = data[2:0];
         CSR_START: sh_start = data;
         CSR_END:   sh_end   = data;
         default:   sh_dur   = data;
      endcase
   endtask

   task automatic set_config(input logic [2:0] c, input logic [15:0] s,
                             input logic [15:0] e, input logic [15:0] d);
      csr_write(CSR_CURVE, {13'd0, c});
      csr_write(CSR_START, s);
      csr_write(CSR_END, e);
      csr_write(CSR_DURATION, d);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      logic signed [15:0] ep;
      logic               ef;
      if (!reset && rsp_valid) begin
         if (exp_pos_q.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("unexpected result pos=%0d", rsp_eased_position);
         end else begin
            ep = exp_pos_q.pop_front();
            ef = exp_fin_q.pop_front();
            n_checked++;
            if (rsp_eased_position !== ep || rsp_finished !== ef) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("mismatch #%0d: pos exp %0d got %0d, finished exp %0b got %0b",
                           n_checked, ep, rsp_eased_position, ef, rsp_finished);
            end
         end
      end
   end

   // extreme start and end on every curve, with durations 1000, 65535 and 1 in turn
   task automatic test_directed;
      logic [15:0] durs[3] = '{16'd1000, 16'd65535, 16'd1};
      for (int c = 0; c < 8; c++) begin
         set_config(c[2:0], 16'h8000, 16'h7FFF, durs[c % 3]);
         send_sample(16'd0);
         send_sample(sh_dur - 16'd1);
         send_sample(sh_dur >> 1);
         send_sample(sh_dur);
         send_sample(16'hFFFF);
         drain();
      end
      // reversed range and zero duration
      set_config(CURVE_BACK, 16'h7FFF, 16'h8000, 16'd300);
      send_sample(16'd40);
      send_sample(16'd260);
      drain();
      set_config(CURVE_EXPO, 16'd5, 16'hFFF0, 16'd0);
      send_sample(16'd0);
      send_sample(16'hFFFF);
      drain();
   endtask

   // random configurations, bursty sample traffic
   task automatic test_random;
      logic [15:0] d, el;
      int n;
      for (int ph = 0; ph < 30; ph++) begin
         case ($urandom_range(0, 5))
            0:       d = 16'hFFFF;
            1:       d = 16'($urandom_range(1, 4));
            2:       d = 16'($urandom);
            default: d = 16'($urandom_range(5, 3000));
         endcase
         set_config(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom), d);
         n = 0;
         while (n < 60) begin
            for (int b = $urandom_range(1, 12); b > 0 && n < 60; b--) begin
               if ($urandom_range(0, 9) == 0) el = 16'($urandom);
               else el = 16'($urandom_range(0, sh_dur));
               send_sample(el);
               n++;
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
         end
         drain();
      end
   endtask

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_elapsed_ms   <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_CURVE;
      csr_write_data   <= '0;
      sh_curve = 3'd0;
      sh_start = 16'sd0;
      sh_end   = 16'sd0;
      sh_dur   = 16'd1000;
      n_sent = 0; n_checked = 0; n_errors = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // defaults straight out of reset
      send_sample(16'd500);
      send_sample(16'd1000);
      drain();
      test_directed();
      test_random();
      $display("sent %0d samples, checked %0d results, %0d mismatches", n_sent, n_checked,
               n_errors);
      $display("samples per curve: %0d %0d %0d %0d %0d %0d %0d %0d", curve_hits[0],
               curve_hits[1], curve_hits[2], curve_hits[3], curve_hits[4], curve_hits[5],
               curve_hits[6], curve_hits[7]);
      if (n_errors == 0 && exp_pos_q.size() == 0)
         $display("[easing_curve_evaluator] OK");
      else
         $display("[easing_curve_evaluator] ERROR");
      $finish;
   end

endmodule
